/* rtl/core/brkg_pkg.sv */
// Shared constants for the group-reversing stream buffer.
// Used by block_reverse_k_group and its port checker; no dependencies.
`default_nettype none

package brkg_pkg;

	localparam int MAX_GROUP  = 16;
	localparam int DATA_WIDTH = 16;
	localparam int IDX_W      = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CNT_W      = $clog2(MAX_GROUP + 1);
	localparam int SIZE_W     = 5;

endpackage

`default_nettype wire

/* rtl/core/block_reverse_k_group.sv */
// Group-reversing stream buffer: one data memory with a registered read port.
// Depends on brkg_pkg for sizes.
`default_nettype none

// Items are written into a 16-entry memory, one per cycle, with in_stall low.
// An item that fills a group of group_size items (or carries final_item)
// starts a readout: the input stalls while the group is read out through
// the single read port, one memory read per cycle unless out_stall holds
// results back, newest first for a full group and in arrival order for a
// partial group closed by final_item. An output register and the read data
// stage let the next items be written while the last results of a group
// wait downstream.
// group_size 0 acts as 1, above 16 as 16; write it only while idle.
module block_reverse_k_group (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration write
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [brkg_pkg::SIZE_W-1:0]       group_size,
	// input items
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [brkg_pkg::DATA_WIDTH-1:0]   item_value,
	input  wire                               final_item,
	// result items
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [brkg_pkg::DATA_WIDTH-1:0]   out_value,
	output logic                              last_of_run,
	output logic                              end_of_sequence
);

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	localparam int IDX_W  = brkg_pkg::IDX_W;
	localparam int CNT_W  = brkg_pkg::CNT_W;
	localparam int SIZE_W = brkg_pkg::SIZE_W;
	localparam int DW     = brkg_pkg::DATA_WIDTH;

	state_t             state_q;
	logic [SIZE_W-1:0]  size_q;
	logic [IDX_W-1:0]   fill_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic               full_q;
	logic               fin_q;

	logic [DW-1:0]      mem [brkg_pkg::MAX_GROUP];
	logic [DW-1:0]      rdata_s1;
	logic               valid_s1;
	logic               last_s1;
	logic               eos_s1;

	logic [DW-1:0]      out_value_q;
	logic               out_valid_q;
	logic               last_q;
	logic               eos_q;

	logic [CNT_W-1:0]   eff_size;
	logic [CNT_W-1:0]   count_new;
	logic               full_new;
	logic               in_take;
	logic               emit;
	logic               move_s1;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               rd_last;

	// Configuration register: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			size_q <= group_size;
		end
	end

	// Clamp the group size to 1..MAX_GROUP
	always_comb begin
		if (size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (32'(size_q) > brkg_pkg::MAX_GROUP) begin
			eff_size = CNT_W'(brkg_pkg::MAX_GROUP);
		end else begin
			eff_size = CNT_W'(size_q);
		end
	end

	// Decide whether the incoming item closes a group
	assign in_stall  = (state_q == ST_DRAIN);
	assign in_take   = in_valid && !in_stall;
	assign count_new = CNT_W'(fill_q) + CNT_W'(1);
	assign full_new  = (count_new >= eff_size);
	assign emit      = in_take && (full_new || final_item);

	// Readout addressing: reversed for a full group, forward otherwise
	assign move_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign rd_en   = (state_q == ST_DRAIN) && (!valid_s1 || move_s1);
	assign rd_last = (CNT_W'(idx_q) == count_q - CNT_W'(1));
	always_comb begin
		if (full_q) begin
			rd_addr = IDX_W'(count_q - CNT_W'(1) - CNT_W'(idx_q));
		end else begin
			rd_addr = idx_q;
		end
	end

	// Control: fill tracking and readout sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			full_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (emit) begin
						state_q <= ST_DRAIN;
						count_q <= count_new;
						idx_q   <= '0;
						full_q  <= full_new;
						fin_q   <= final_item;
						fill_q  <= '0;
					end else if (in_take) begin
						fill_q <= IDX_W'(count_new);
					end
				end
				ST_DRAIN: begin
					if (rd_en) begin
						idx_q <= idx_q + IDX_W'(1);
						if (rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Data memory: write on accept, registered read during readout
	always_ff @(posedge clk) begin
		if (in_take) begin
			mem[fill_q] <= item_value;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Read stage flags travel with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_en) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			last_s1 <= rd_last;
			eos_s1  <= rd_last && fin_q;
		end
	end

	// Output register: load from the read stage, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_value_q <= rdata_s1;
			last_q      <= last_s1;
			eos_q       <= eos_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign last_of_run     = last_q;
	assign end_of_sequence = eos_q;

endmodule

`default_nettype wire

/* rtl/core/brkg_checker.sv */
// Port-level checker for block_reverse_k_group, bound to the top level.
// Depends on brkg_pkg for field widths.
`default_nettype none

module brkg_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             cfg_valid,
	input wire                             cfg_ready,
	input wire [brkg_pkg::SIZE_W-1:0]      group_size,
	input wire                             in_valid,
	input wire                             in_stall,
	input wire                             final_item,
	input wire                             out_valid,
	input wire                             out_stall,
	input wire [brkg_pkg::DATA_WIDTH-1:0]  out_value,
	input wire                             last_of_run,
	input wire                             end_of_sequence
);

	logic [brkg_pkg::SIZE_W-1:0] size_q;

	// Track the group size as written through the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= brkg_pkg::SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			size_q <= group_size;
		end
	end

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value)
			&& $stable(last_of_run) && $stable(end_of_sequence))
		else $error("stalled result changed");

	// End of sequence only on the last result of a run
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_sequence |-> last_of_run)
		else $error("end_of_sequence without last_of_run");

	// A final item always starts a readout
	a_final_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && final_item |=> in_stall)
		else $error("final item did not start a readout");

	// Group size of one emits every item
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (size_q == '0 || size_q == brkg_pkg::SIZE_W'(1))
			|=> in_stall)
		else $error("group size one did not emit the item");

endmodule

bind block_reverse_k_group brkg_checker u_brkg_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cfg_valid       (cfg_valid),
	.cfg_ready       (cfg_ready),
	.group_size      (group_size),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.final_item      (final_item),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.out_value       (out_value),
	.last_of_run     (last_of_run),
	.end_of_sequence (end_of_sequence)
);

`default_nettype wire

/* tb/sv/tb_block_reverse_k_group.sv */
`timescale 1ns / 1ps
// Self-checking testbench for block_reverse_k_group: directed rows, then random sequences.
// Depends on brkg_pkg and the block_reverse_k_group RTL only.

module tb_block_reverse_k_group;

	localparam int CLOCK_HALF    = 2;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int SEQS_PER_PHASE = 5;

	typedef struct packed {
		logic [brkg_pkg::DATA_WIDTH-1:0] value;
		logic                            run_end;
		logic                            seq_end;
	} result_t;

	typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [brkg_pkg::SIZE_W-1:0]     size;
		logic [brkg_pkg::DATA_WIDTH-1:0] value;
		logic                            fin;
		logic                            has_fixed;
		result_t                         fixed;
	} plan_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [brkg_pkg::SIZE_W-1:0]      group_size;
	logic                             in_valid;
	logic                             in_stall;
	logic [brkg_pkg::DATA_WIDTH-1:0]  item_value;
	logic                             final_item;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [brkg_pkg::DATA_WIDTH-1:0]  out_value;
	logic                             last_of_run;
	logic                             end_of_sequence;

	// reorder predictor state
	logic [brkg_pkg::SIZE_W-1:0]      model_size;
	logic [brkg_pkg::DATA_WIDTH-1:0]  model_buf [brkg_pkg::MAX_GROUP];
	int                               model_fill;
	result_t                          group_burst [$];
	result_t                          expected_results [$];
	result_t                          want;

	plan_row_t              plan [$];
	int                     send_idle_pct;
	int                     recv_idle_pct;
	int                     error_count = 0;
	int                     quiet_cycles = 0;
	int                     idle_plan [3][2] = '{'{17, 57}, '{57, 17}, '{0, 0}};

	block_reverse_k_group DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.group_size      (group_size),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.item_value      (item_value),
		.final_item      (final_item),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_value       (out_value),
		.last_of_run     (last_of_run),
		.end_of_sequence (end_of_sequence)
	);

	// Free-running clock
	always begin
		#CLOCK_HALF clk = 1'b1;
		#CLOCK_HALF clk = 1'b0;
	end

	// Buffer one item and work out the results it releases into group_burst
	function automatic void reorder_item(input logic [brkg_pkg::DATA_WIDTH-1:0] v,
			input logic fin);
		int k;
		int cnt;
		logic full;
		result_t r;
		k = (model_size == 0) ? 1 : ((model_size > brkg_pkg::MAX_GROUP) ?
			brkg_pkg::MAX_GROUP : int'(model_size));
		group_burst = {};
		if (model_fill >= brkg_pkg::MAX_GROUP)
			model_fill = brkg_pkg::MAX_GROUP - 1;
		model_buf[model_fill] = v;
		cnt = model_fill + 1;
		full = (cnt >= k);
		if (!full && !fin) begin
			model_fill = cnt;
			return;
		end
		for (int i = 0; i < cnt; i++) begin
			r.value   = model_buf[full ? (cnt - 1 - i) : i];
			r.run_end = (i + 1 == cnt);
			r.seq_end = (i + 1 == cnt) && fin;
			group_burst.push_back(r);
		end
		model_fill = 0;
	endfunction

	// Favor small groups, sometimes anything the register holds
	function automatic logic [brkg_pkg::SIZE_W-1:0] pick_group_size();
		if ($urandom_range(0, 3) == 0)
			return brkg_pkg::SIZE_W'($urandom_range(0, 31));
		return brkg_pkg::SIZE_W'($urandom_range(1, 6));
	endfunction

	function automatic void add_cfg(input logic [brkg_pkg::SIZE_W-1:0] s);
		plan_row_t row;
		row = '{kind: ROW_CFG, size: s, value: '0, fin: 1'b0, has_fixed: 1'b0, fixed: '0};
		plan.push_back(row);
	endfunction

	function automatic void add_item(input logic [brkg_pkg::DATA_WIDTH-1:0] v,
			input logic fin, input logic has_fixed = 1'b0, input result_t fixed = '0);
		plan_row_t row;
		row = '{kind: ROW_ITEM, size: '0, value: v, fin: fin, has_fixed: has_fixed,
			fixed: fixed};
		plan.push_back(row);
	endfunction

	// Present one item, hold it until accepted, then record its expected results
	task automatic send_item(input logic [brkg_pkg::DATA_WIDTH-1:0] v, input logic fin,
			input logic has_fixed, input result_t fixed);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		item_value <= v;
		final_item <= fin;
		do @(posedge clk); while (in_stall);
		reorder_item(v, fin);
		if (has_fixed)
			expected_results.push_back(fixed);
		else
			foreach (group_burst[i]) expected_results.push_back(group_burst[i]);
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected result, then let the block settle
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the group size register; call only from a drained state at a falling edge
	task automatic write_group_size(input logic [brkg_pkg::SIZE_W-1:0] s);
		cfg_valid  <= 1'b1;
		group_size <= s;
		do @(posedge clk); while (!cfg_ready);
		model_size = s;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Randomize receiver back-pressure at each falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Compare each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual value %h last %b end %b",
					$time, out_value, last_of_run, end_of_sequence);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (out_value !== want.value) begin
					$display("%0t: out_value expected %h actual %h", $time, want.value, out_value);
					error_count++;
				end
				if (last_of_run !== want.run_end) begin
					$display("%0t: last_of_run expected %b actual %b", $time, want.run_end,
						last_of_run);
					error_count++;
				end
				if (end_of_sequence !== want.seq_end) begin
					$display("%0t: end_of_sequence expected %b actual %b", $time, want.seq_end,
						end_of_sequence);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_block_reverse_k_group: errors");
			$finish;
		end
	end

	initial begin
		int len;
		int split;
		logic fin;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		group_size    = '0;
		in_valid      = 1'b0;
		item_value    = '0;
		final_item    = 1'b0;
		send_idle_pct = idle_plan[0][0];
		recv_idle_pct = idle_plan[0][1];
		model_size    = 1;
		model_fill    = 0;

		// Directed rows: pass-through after reset, size zero, saturated size,
		// a full group closed by the final item, a size change mid-group,
		// and a partial group flushed in arrival order
		add_item(16'hFFFF, 1'b0, 1'b1, '{value: 16'hFFFF, run_end: 1'b1, seq_end: 1'b0});
		add_item(16'h0000, 1'b1, 1'b1, '{value: 16'h0000, run_end: 1'b1, seq_end: 1'b1});
		add_item(16'hA5A5, 1'b0);
		add_cfg(5'd0);
		add_item(16'h5A5A, 1'b1, 1'b1, '{value: 16'h5A5A, run_end: 1'b1, seq_end: 1'b1});
		add_cfg(5'd31);
		for (int i = 0; i < brkg_pkg::MAX_GROUP; i++)
			add_item(brkg_pkg::DATA_WIDTH'(16'h1000 + i * 16'h0111),
				i == brkg_pkg::MAX_GROUP - 1);
		add_cfg(5'd4);
		add_item(16'h0001, 1'b0);
		add_item(16'hFFFE, 1'b0);
		add_cfg(5'd2);
		add_item(16'h8000, 1'b0);
		add_cfg(5'd3);
		add_item(16'h7FFF, 1'b0);
		add_item(16'h00FF, 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				wait_drain();
				write_group_size(plan[r].size);
			end else begin
				send_item(plan[r].value, plan[r].fin, plan[r].has_fixed, plan[r].fixed);
			end
		end

		// Random sequences, one idling profile per phase
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = idle_plan[p][0];
			recv_idle_pct = idle_plan[p][1];
			for (int s = 0; s < SEQS_PER_PHASE; s++) begin
				wait_drain();
				write_group_size(pick_group_size());
				len = $urandom_range(1, 20);
				split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : -1;
				for (int i = 0; i < len; i++) begin
					// Occasionally resize in the middle of a group
					if (i == split) begin
						wait_drain();
						write_group_size(pick_group_size());
					end
					fin = (i == len - 1) || ($urandom_range(0, 15) == 0);
					send_item(brkg_pkg::DATA_WIDTH'($urandom_range(0, 65535)), fin, 1'b0, '0);
				end
			end
		end

		wait_drain();
		if (error_count == 0)
			$display("tb_block_reverse_k_group: clean");
		else
			$display("tb_block_reverse_k_group: errors");
		$finish;
	end

endmodule
